// ===== hdl/tfs_pkg.sv =====
// package for the telemetry frame scheduler
// types, codes and constants shared by the divider unit and the top level
package tfs_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam logic [31:0] DEFAULT_CHANNEL_MASK = 32'h0000_0003;
  localparam logic [31:0] STATUS_PERIOD_MS = 32'd100;
  localparam int DIV_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [2:0] {
    KIND_FAST  = 3'd0,
    KIND_SLOW  = 3'd1,
    KIND_EVENT = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_MASK  = 3'd4,
    KIND_RATE  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    SEND_NONE   = 3'd0,
    SEND_WAVE   = 3'd1,
    SEND_EVENT  = 3'd2,
    SEND_ACK    = 3'd3,
    SEND_STATUS = 3'd4
  } send_t;

  typedef enum logic [1:0] {
    OWN_IDLE = 2'd0,
    OWN_WAVE = 2'd1,
    OWN_SLOW = 2'd2
  } owner_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMITED = 2'd1,
    ST_REJECT  = 2'd2
  } cmd_status_t;

  localparam logic [7:0] ACK_CMD_MASK = 8'd0;
  localparam logic [7:0] ACK_CMD_RATE = 8'd1;

  typedef enum logic [2:0] {
    REG_STREAM_ENABLE  = 3'd0,
    REG_STREAM_SUSPEND = 3'd1,
    REG_PWM_FREQ       = 3'd2,
    REG_MIN_DIVIDER    = 3'd3,
    REG_RATE_MIN       = 3'd4,
    REG_RATE_MAX       = 3'd5,
    REG_FAULT_TRIP_ID  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_DIV1,
    S_DIV2,
    S_ACK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/tfs_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on tfs_pkg
module tfs_divider import tfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [DIV_W:0] trial;
  logic [DIV_W:0] shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[DIV_W-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DIV_W]) begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider busy with zero count");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("divider done without run");

endmodule

// ===== hdl/telemetry_frame_scheduler.sv =====
// telemetry frame scheduler top level: state, sequencer and result register
// depends on tfs_pkg and tfs_divider
//
//  channel | handshake          | payload
//  in_     | in_valid/in_ready  | kind, now_ms, uart_ready, start_ok, command, event fields
//  out_    | out_valid/out_ready| send_kind, sequence_res, stamp_ms, frame fields, status
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// each request has its mask bits counted two at a time in S_POP, then goes via S_OUT
// to the result register; set-mask and set-rate queue an ack whose rate needs a pass
// of the shared divider, and an accepted set-rate needs two passes
// synchronous active-low reset; out_valid holds until out_ready, and in_ready stays
// low until the result is taken
module telemetry_frame_scheduler import tfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_now_ms,
  input  logic        in_uart_ready,
  input  logic        in_start_ok,
  input  logic [31:0] in_command_value,
  input  logic [7:0]  in_event_code,
  input  logic [7:0]  in_motor_fault_code,
  input  logic [7:0]  in_shunt_fault_code,
  input  logic [31:0] in_event_detail,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_send_kind,
  output logic [15:0] out_sequence_res,
  output logic [31:0] out_stamp_ms,
  output logic [7:0]  out_frame_tag,
  output logic [7:0]  out_frame_code_a,
  output logic [7:0]  out_frame_code_b,
  output logic [31:0] out_frame_word,
  output logic [15:0] out_frame_rate_hz,
  output logic [4:0]  out_channel_count,
  output logic [1:0]  out_command_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // config registers
  logic        en_r, susp_r;
  logic [16:0] pwm_r;
  logic [15:0] mindiv_r, rmin_r, rmax_r;
  logic [7:0]  trip_r;

  // scheduler state
  owner_t      owner_r, owner_nxt;
  logic [15:0] dec_r, dec_nxt, div_r, div_nxt, wseq_r, wseq_nxt, sseq_r, sseq_nxt;
  logic [31:0] mask_r, mask_nxt, last_r, last_nxt;
  logic        stp_r, stp_nxt, evp_r, evp_nxt, ackp_r, ackp_nxt;
  logic [7:0]  evid_r, evid_nxt, evm_r, evm_nxt, evs_r, evs_nxt;
  logic [31:0] evd_r, evd_nxt;
  logic [7:0]  ackc_r, ackc_nxt;
  logic [1:0]  acks_r, acks_nxt;
  logic [31:0] ackm_r, ackm_nxt;
  logic [15:0] ackrt_r, ackrt_nxt;

  // request capture
  kind_t       kind_r;
  logic [31:0] now_r, cmd_r;
  logic        rdy_r, ok_r;
  logic [7:0]  ev_id_in_r, ev_m_in_r, ev_s_in_r;
  logic [31:0] ev_d_in_r;
  logic [31:0] pop_r, pop_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  state_t      state_r, state_nxt;

  // result register
  logic        ov_r, ov_nxt;
  logic [2:0]  o_kind_r, o_kind_nxt;
  logic [15:0] o_seq_r, o_seq_nxt;
  logic [31:0] o_stamp_r, o_stamp_nxt;
  logic [7:0]  o_tag_r, o_tag_nxt, o_a_r, o_a_nxt, o_b_r, o_b_nxt;
  logic [31:0] o_word_r, o_word_nxt;
  logic [15:0] o_rate_r, o_rate_nxt;
  logic [4:0]  o_cnt_r, o_cnt_nxt;
  logic [1:0]  o_st_r, o_st_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  tfs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic        in_fire;
  logic [31:0] q, r;
  logic [15:0] dsel;
  logic [31:0] dclamp;
  logic [1:0]  pair;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign q = drsp.quotient;
  assign r = drsp.remainder;
  assign pair = 2'(pop_r[0]) + 2'(pop_r[1]);

  always_comb begin
    state_nxt = state_r;
    owner_nxt = owner_r; dec_nxt = dec_r; div_nxt = div_r;
    wseq_nxt = wseq_r; sseq_nxt = sseq_r; mask_nxt = mask_r; last_nxt = last_r;
    stp_nxt = stp_r; evp_nxt = evp_r; ackp_nxt = ackp_r;
    evid_nxt = evid_r; evm_nxt = evm_r; evs_nxt = evs_r; evd_nxt = evd_r;
    ackc_nxt = ackc_r; acks_nxt = acks_r; ackm_nxt = ackm_r; ackrt_nxt = ackrt_r;
    pop_nxt = pop_r; cnt_nxt = cnt_r;
    ov_nxt = ov_r;
    o_kind_nxt = o_kind_r; o_seq_nxt = o_seq_r; o_stamp_nxt = o_stamp_r;
    o_tag_nxt = o_tag_r; o_a_nxt = o_a_r; o_b_nxt = o_b_r; o_word_nxt = o_word_r;
    o_rate_nxt = o_rate_r; o_cnt_nxt = o_cnt_r; o_st_nxt = o_st_r;
    dreq = '0;
    dsel = (div_r == '0) ? 16'd1 : div_r;
    dclamp = '0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pop_nxt = (in_kind == KIND_MASK) ? in_command_value : mask_r;
          cnt_nxt = '0;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        // count bits two per cycle; once done, clear result defaults and handle the request
        cnt_nxt = 6'(cnt_r + 6'(pair));
        pop_nxt = {2'b00, pop_r[31:2]};
        if (pop_r == '0) begin
          o_kind_nxt = SEND_NONE; o_seq_nxt = '0; o_stamp_nxt = '0; o_tag_nxt = '0;
          o_a_nxt = '0; o_b_nxt = '0; o_word_nxt = '0; o_rate_nxt = '0;
          o_cnt_nxt = '0; o_st_nxt = '0;
          state_nxt = S_OUT;
          case (kind_r)
            KIND_FAST: begin
              if (en_r && !susp_r && mask_r != '0) begin
                dec_nxt = dec_r + 16'd1;
                if (dec_nxt >= div_r) begin
                  dec_nxt = '0;
                  if (owner_r == OWN_IDLE && rdy_r) begin
                    wseq_nxt = wseq_r + 16'd1;
                    if (!ok_r) owner_nxt = OWN_IDLE;
                    else begin
                      owner_nxt = OWN_WAVE;
                      o_kind_nxt = SEND_WAVE;
                      o_seq_nxt = wseq_r;
                      o_stamp_nxt = now_r;
                      o_word_nxt = mask_r;
                      o_cnt_nxt = (cnt_r > 6'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : 5'(cnt_r);
                    end
                  end
                end
              end
            end
            KIND_SLOW: begin
              stp_nxt = stp_r || ((now_r - last_r) >= STATUS_PERIOD_MS);
              if ((evp_r || ackp_r || stp_nxt) && !susp_r && owner_r == OWN_IDLE
                  && rdy_r) begin
                sseq_nxt = sseq_r + 16'd1;
                if (!ok_r) owner_nxt = OWN_IDLE;
                else begin
                  owner_nxt = OWN_SLOW;
                  o_seq_nxt = sseq_r;
                  if (evp_r) begin
                    evp_nxt = 1'b0; o_kind_nxt = SEND_EVENT; o_stamp_nxt = now_r;
                    o_tag_nxt = evid_r; o_a_nxt = evm_r; o_b_nxt = evs_r;
                    o_word_nxt = evd_r;
                  end else if (ackp_r) begin
                    ackp_nxt = 1'b0; o_kind_nxt = SEND_ACK; o_tag_nxt = ackc_r;
                    o_a_nxt = {6'd0, acks_r}; o_word_nxt = ackm_r; o_rate_nxt = ackrt_r;
                  end else begin
                    stp_nxt = 1'b0; last_nxt = now_r; o_kind_nxt = SEND_STATUS;
                    o_stamp_nxt = now_r;
                  end
                end
              end
            end
            KIND_EVENT: begin
              // a pending fault-trip event is kept unless the new event is also a fault trip
              if (!(evp_r && evid_r == trip_r && ev_id_in_r != trip_r)) begin
                evid_nxt = ev_id_in_r; evm_nxt = ev_m_in_r; evs_nxt = ev_s_in_r;
                evd_nxt = ev_d_in_r;
                evp_nxt = 1'b1;
              end
            end
            KIND_DONE: owner_nxt = OWN_IDLE;
            KIND_MASK: begin
              if (cnt_r > 6'(MAX_CHANNELS)) acks_nxt = ST_LIMITED;
              else begin
                mask_nxt = cmd_r;
                acks_nxt = ST_OK;
              end
              ackc_nxt = ACK_CMD_MASK;
              state_nxt = S_ACK;
              dreq.start = 1'b1; dreq.dividend = {15'd0, pwm_r}; dreq.divisor = {16'd0, dsel};
            end
            KIND_RATE: begin
              ackc_nxt = ACK_CMD_RATE;
              if (cmd_r == '0 || cmd_r < {16'd0, rmin_r} || cmd_r > {16'd0, rmax_r}) begin
                acks_nxt = ST_REJECT;
                state_nxt = S_ACK;
                dreq.start = 1'b1; dreq.dividend = {15'd0, pwm_r};
                dreq.divisor = {16'd0, dsel};
              end else begin
                state_nxt = S_DIV1;
                dreq.start = 1'b1; dreq.dividend = {15'd0, pwm_r}; dreq.divisor = cmd_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV1: begin
        if (drsp.done) begin
          dclamp = (q < {16'd0, mindiv_r}) ? {16'd0, mindiv_r} : q;
          div_nxt = (dclamp > 32'd65535) ? 16'hFFFF : dclamp[15:0];
          dec_nxt = '0;
          acks_nxt = (r == '0) ? ST_OK : ST_LIMITED;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        dreq.start = 1'b1; dreq.dividend = {15'd0, pwm_r}; dreq.divisor = {16'd0, dsel};
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (drsp.done) begin
          ackm_nxt = mask_r;
          ackrt_nxt = (q > 32'd65535) ? 16'hFFFF : q[15:0];
          ackp_nxt = 1'b1;
          o_st_nxt = acks_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      en_r <= 1'b1; susp_r <= 1'b0; pwm_r <= 17'd20000; mindiv_r <= 16'd40;
      rmin_r <= 16'd1; rmax_r <= 16'd500; trip_r <= 8'd1;
      owner_r <= OWN_IDLE; dec_r <= '0; div_r <= 16'd40; mask_r <= DEFAULT_CHANNEL_MASK;
      wseq_r <= '0; sseq_r <= '0; last_r <= '0;
      stp_r <= 1'b0; evp_r <= 1'b0; ackp_r <= 1'b0;
      evid_r <= '0; evm_r <= '0; evs_r <= '0; evd_r <= '0;
      ackc_r <= '0; acks_r <= '0; ackm_r <= '0; ackrt_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      owner_r <= owner_nxt; dec_r <= dec_nxt; div_r <= div_nxt; mask_r <= mask_nxt;
      wseq_r <= wseq_nxt; sseq_r <= sseq_nxt; last_r <= last_nxt;
      stp_r <= stp_nxt; evp_r <= evp_nxt; ackp_r <= ackp_nxt;
      evid_r <= evid_nxt; evm_r <= evm_nxt; evs_r <= evs_nxt; evd_r <= evd_nxt;
      ackc_r <= ackc_nxt; acks_r <= acks_nxt; ackm_r <= ackm_nxt; ackrt_r <= ackrt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_STREAM_ENABLE:  en_r <= cfg_data[0];
          REG_STREAM_SUSPEND: susp_r <= cfg_data[0];
          REG_PWM_FREQ:       pwm_r <= cfg_data[16:0];
          REG_MIN_DIVIDER:    mindiv_r <= cfg_data[15:0];
          REG_RATE_MIN:       rmin_r <= cfg_data[15:0];
          REG_RATE_MAX:       rmax_r <= cfg_data[15:0];
          REG_FAULT_TRIP_ID:  trip_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    if (in_fire) begin
      kind_r <= kind_t'(in_kind); now_r <= in_now_ms; cmd_r <= in_command_value;
      rdy_r <= in_uart_ready; ok_r <= in_start_ok;
      ev_id_in_r <= in_event_code; ev_m_in_r <= in_motor_fault_code;
      ev_s_in_r <= in_shunt_fault_code; ev_d_in_r <= in_event_detail;
    end
    pop_r <= pop_nxt; cnt_r <= cnt_nxt;
    o_kind_r <= o_kind_nxt; o_seq_r <= o_seq_nxt; o_stamp_r <= o_stamp_nxt;
    o_tag_r <= o_tag_nxt; o_a_r <= o_a_nxt; o_b_r <= o_b_nxt; o_word_r <= o_word_nxt;
    o_rate_r <= o_rate_nxt; o_cnt_r <= o_cnt_nxt; o_st_r <= o_st_nxt;
  end

  assign out_valid = ov_r;
  assign out_send_kind = o_kind_r;
  assign out_sequence_res = o_seq_r;
  assign out_stamp_ms = o_stamp_r;
  assign out_frame_tag = o_tag_r;
  assign out_frame_code_a = o_a_r;
  assign out_frame_code_b = o_b_r;
  assign out_frame_word = o_word_r;
  assign out_frame_rate_hz = o_rate_r;
  assign out_channel_count = o_cnt_r;
  assign out_command_status = o_st_r;

  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> state_r == S_IDLE)
    else $error("result pending while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(o_kind_r))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACK && drsp.done) |=> ackp_r)
    else $error("ack not queued");

endmodule
